// ===== hdl/bpc_pkg.sv =====
package bpc_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned TickW = 16;
  localparam int unsigned InDataW = 40;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned AddrW = 4;
  localparam int unsigned ApbDataW = 32;

  localparam logic [TickW-1:0] DebounceReset = 16'd30;
  localparam logic [TickW-1:0] LongPressReset = 16'd1500;
  localparam logic [TickW-1:0] ShutdownReset = 16'd3000;

  typedef enum logic [1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_SHUTDOWN   = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    EVT_NONE     = 2'd0,
    EVT_SHORT    = 2'd1,
    EVT_LONG     = 2'd2,
    EVT_SHUTDOWN = 2'd3
  } evt_e;

  typedef struct packed {
    logic [TickW-1:0] debounce_ticks;
    logic [TickW-1:0] long_press_ticks;
    logic [TickW-1:0] shutdown_ticks;
  } cfg_t;

  typedef struct packed {
    logic             pwron_release_edge;
    logic             pwron_press_edge;
    logic             pwron_poll_ok;
    logic             boot_raw_pressed;
    logic [TimeW-1:0] time_now;
  } item_t;

  typedef struct packed {
    evt_e pwron_event;
    evt_e boot_event;
    logic haptic_trigger;
  } res_t;

endpackage

// ===== hdl/bpc_core.sv =====
module bpc_core import bpc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  step_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output res_t  res_o
);

  logic             boot_sampled_q, boot_sampled_d;
  logic             boot_stable_q, boot_stable_d;
  logic [TimeW-1:0] boot_edge_time_q, boot_edge_time_d;
  logic [TimeW-1:0] boot_start_time_q, boot_start_time_d;
  logic             pwron_stable_q, pwron_stable_d;
  logic [TimeW-1:0] pwron_start_time_q, pwron_start_time_d;

  logic [TimeW-1:0] boot_since_edge, boot_held, pwron_held;
  logic             boot_update, pwron_press, pwron_rel;

  always_comb begin
    boot_sampled_d     = item_i.boot_raw_pressed;
    boot_edge_time_d   = (item_i.boot_raw_pressed != boot_sampled_q) ? item_i.time_now
                                                                      : boot_edge_time_q;
    boot_stable_d      = boot_stable_q;
    boot_start_time_d  = boot_start_time_q;
    pwron_stable_d     = pwron_stable_q;
    pwron_start_time_d = pwron_start_time_q;
    res_o              = '{pwron_event: EVT_NONE, boot_event: EVT_NONE, haptic_trigger: 1'b0};

    // boot button, debounced by time
    boot_since_edge = item_i.time_now - boot_edge_time_d;
    boot_held       = item_i.time_now - boot_start_time_q;
    boot_update     = (boot_since_edge >= {16'd0, cfg_i.debounce_ticks})
                      && (item_i.boot_raw_pressed != boot_stable_q);
    if (boot_update) begin
      boot_stable_d = item_i.boot_raw_pressed;
      if (item_i.boot_raw_pressed) begin
        boot_start_time_d    = item_i.time_now;
        res_o.haptic_trigger = 1'b1;
      end else begin
        res_o.boot_event = (boot_held >= {16'd0, cfg_i.long_press_ticks}) ? EVT_LONG
                                                                          : EVT_SHORT;
      end
    end

    // power button, edges taken as they come; press before release
    pwron_press = item_i.pwron_poll_ok && item_i.pwron_press_edge;
    if (pwron_press) begin
      pwron_stable_d       = 1'b1;
      pwron_start_time_d   = item_i.time_now;
      res_o.haptic_trigger = 1'b1;
    end
    pwron_held = item_i.time_now - pwron_start_time_d;
    pwron_rel  = item_i.pwron_poll_ok && item_i.pwron_release_edge && pwron_stable_d;
    if (pwron_rel) begin
      pwron_stable_d = 1'b0;
      if (pwron_held >= {16'd0, cfg_i.shutdown_ticks}) begin
        res_o.pwron_event = EVT_SHUTDOWN;
      end else if (pwron_held >= {16'd0, cfg_i.long_press_ticks}) begin
        res_o.pwron_event = EVT_LONG;
      end else begin
        res_o.pwron_event = EVT_SHORT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boot_sampled_q     <= 1'b0;
      boot_stable_q      <= 1'b0;
      boot_edge_time_q   <= '0;
      boot_start_time_q  <= '0;
      pwron_stable_q     <= 1'b0;
      pwron_start_time_q <= '0;
    end else if (step_i) begin
      boot_sampled_q     <= boot_sampled_d;
      boot_stable_q      <= boot_stable_d;
      boot_edge_time_q   <= boot_edge_time_d;
      boot_start_time_q  <= boot_start_time_d;
      pwron_stable_q     <= pwron_stable_d;
      pwron_start_time_q <= pwron_start_time_d;
    end
  end

endmodule

// ===== hdl/button_press_classifier.sv =====
// an input transaction passes the input register and then the result
// register on the master side; throughput: one transaction per cycle
// unless the master stalls, set by the single classify stage between
// the two registers; reset: asynchronous, active low; all but the data
// registers return to defaults and both buttons are taken as released
module button_press_classifier import bpc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [31:0] time_now, [32] boot_raw_pressed, [33] pwron_poll_ok,
  // [34] pwron_press_edge, [35] pwron_release_edge, [39:36] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] haptic_trigger, [2:1] boot_event, [4:3] pwron_event, [7:5] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     in_v_q;
  item_t    in_q;
  logic     out_v_q;
  res_t     out_q;
  res_t     res;
  logic     adv, step;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks   <= DebounceReset;
      cfg_q.long_press_ticks <= LongPressReset;
      cfg_q.shutdown_ticks   <= ShutdownReset;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_DEBOUNCE:   cfg_q.debounce_ticks   <= pwdata[TickW-1:0];
        REG_LONG_PRESS: cfg_q.long_press_ticks <= pwdata[TickW-1:0];
        REG_SHUTDOWN:   cfg_q.shutdown_ticks   <= pwdata[TickW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEBOUNCE:   prdata = {16'd0, cfg_q.debounce_ticks};
      REG_LONG_PRESS: prdata = {16'd0, cfg_q.long_press_ticks};
      REG_SHUTDOWN:   prdata = {16'd0, cfg_q.shutdown_ticks};
      default:        prdata = '0;
    endcase
  end

  // two-register pipeline
  assign adv           = !out_v_q || m_axis_tready;
  assign step          = in_v_q && adv;
  assign s_axis_tready = !in_v_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_v_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_v_q <= in_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= item_t'(s_axis_tdata[$bits(item_t)-1:0]);
    end
    if (step) begin
      out_q <= res;
    end
  end

  bpc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {3'd0, out_q};

  a_boot_no_shutdown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> out_q.boot_event != EVT_SHUTDOWN)
    else $error("boot event carries shutdown code");

  a_step_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_v_q)
    else $error("classified item lost");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_v_q && out_v_q)
    else $error("input stalled with a free stage");

endmodule
